/* hdl/srq_pkg.sv */
// ---------------------------------------------------------------------------
// srq_pkg: shared types and codes for the sample ring queue
// operation codes, field widths and the stored record layout
// ---------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CNT_W    = 7;

  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_RDALL  = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // one stored sample record, 51 bits
  typedef struct packed {
    logic                       ecg_on;
    logic                       right_off;
    logic                       left_off;
    logic signed [SAMPLE_W-1:0] ecg;
    logic signed [SAMPLE_W-1:0] resp;
  } rec_t;

endpackage

`default_nettype wire

/* hdl/srq_store.sv */
// ---------------------------------------------------------------------------
// srq_store: record memory of the ring queue
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module srq_store #(
  parameter int DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [$clog2(DEPTH)-1:0]     wr_addr,
  input  srq_pkg::rec_t               wr_data,
  input  wire                         rd_en,
  input  wire [$clog2(DEPTH)-1:0]     rd_addr,
  output srq_pkg::rec_t               rd_data
);

  srq_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/sample_ring_queue_with_snapshot.sv */
// ---------------------------------------------------------------------------
// sample_ring_queue_with_snapshot: ring queue of ecg sample records
// enqueue, dequeue, non-destructive read-all and status over one channel
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one operation per transfer;
//   result channel (out_valid / out_stall) returns the results, last marks
//   the final result of an operation
//   the block works on one operation at a time: in_stall is high from the
//   transfer until the operation's last result sits in the output register
//   enqueue, dequeue and status: the exec state carries out the operation and
//   the emit state puts the result in the output register when that is free
//   read all: the exec state starts the first memory read, then the read-all
//   emit state sends one record per cycle from the read port while not stalled
//   a stalled receiver holds the output register; the sequencer waits on it
//   the index step unit (increment and wrap at capacity) is shared by the
//   head, tail and read-all walk
//   reset empties the queue and sets capacity to DEPTH; memory is not cleared
//   a capacity write (cfg_we) also empties the queue
// ---------------------------------------------------------------------------
`default_nettype none

module sample_ring_queue_with_snapshot #(
  parameter int DEPTH = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration
  input  wire                                  cfg_we,
  input  wire [srq_pkg::CNT_W-1:0]             cfg_wdata,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [1:0]                            in_op,
  input  wire signed [srq_pkg::SAMPLE_W-1:0]   in_resp_in,
  input  wire signed [srq_pkg::SAMPLE_W-1:0]   in_ecg_in,
  input  wire                                  in_left_off_in,
  input  wire                                  in_right_off_in,
  input  wire                                  in_ecg_on_in,
  input  wire [srq_pkg::CNT_W-1:0]             in_read_limit,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 out_ok,
  output logic signed [srq_pkg::SAMPLE_W-1:0]  out_resp_out,
  output logic signed [srq_pkg::SAMPLE_W-1:0]  out_ecg_out,
  output logic                                 out_left_off_out,
  output logic                                 out_right_off_out,
  output logic                                 out_ecg_on_out,
  output logic                                 out_last,
  output logic [srq_pkg::CNT_W-1:0]            out_count,
  output logic                                 out_full_res,
  output logic                                 out_empty_res
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [srq_pkg::CNT_W-1:0] DEPTH_C = srq_pkg::CNT_W'(DEPTH);
  localparam logic [srq_pkg::CNT_W-1:0] ONE_C   = srq_pkg::CNT_W'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_EMIT    = 2'd2;
  localparam logic [1:0] S_RA_EMIT = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [srq_pkg::CNT_W-1:0]   cap_r, cap_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [IW-1:0]               tail_r, tail_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [srq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [srq_pkg::CNT_W-1:0]   rem_r, rem_nxt;

  // latched operation
  logic [1:0]                  op_r;
  srq_pkg::rec_t               rec_r;
  logic [srq_pkg::CNT_W-1:0]   limit_r;

  // pending single result
  logic                        ok_r, ok_nxt;
  logic                        use_rd_r, use_rd_nxt;

  // output register
  logic                        out_valid_r;
  srq_pkg::rec_t               out_rec_r;
  logic                        out_ok_r, out_last_r, out_full_r, out_empty_r;
  logic [srq_pkg::CNT_W-1:0]   out_count_r;

  logic                        in_xfer;
  logic                        slot_free;
  logic                        load_out;
  logic                        load_last;
  logic                        load_ok;
  srq_pkg::rec_t               load_rec;

  // memory ports
  logic                        wr_en;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  srq_pkg::rec_t               rd_data;

  // shared index step unit
  logic [IW-1:0]               step_in;
  logic [IW-1:0]               step_out;
  logic [srq_pkg::CNT_W-1:0]   step_sum;

  logic [srq_pkg::CNT_W-1:0]   cap_wr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // step unit: increment, wrap at capacity
  always_comb begin
    if (state_r == S_RA_EMIT) begin
      step_in = idx_r;
    end else if (op_r == srq_pkg::OP_ENQ) begin
      step_in = tail_r;
    end else begin
      step_in = head_r;
    end
    step_sum = srq_pkg::CNT_W'(step_in) + ONE_C;
    if (step_sum >= cap_r) begin
      step_out = '0;
    end else begin
      step_out = step_sum[IW-1:0];
    end
  end

  // capacity clamp on write
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_wr = ONE_C;
    end else if (cfg_wdata > DEPTH_C) begin
      cap_wr = DEPTH_C;
    end else begin
      cap_wr = cfg_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cap_nxt    = cap_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    ok_nxt     = ok_r;
    use_rd_nxt = use_rd_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    load_out   = 1'b0;
    load_last  = 1'b1;
    load_ok    = ok_r;
    load_rec   = use_rd_r ? rd_data : '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt     = 1'b1;
        use_rd_nxt = 1'b0;
        state_nxt  = S_EMIT;
        case (op_r)
          srq_pkg::OP_ENQ: begin
            if (count_r >= cap_r) begin
              ok_nxt = 1'b0;
            end else begin
              wr_en     = 1'b1;
              tail_nxt  = step_out;
              count_nxt = count_r + ONE_C;
            end
          end
          srq_pkg::OP_DEQ: begin
            if (count_r == '0) begin
              ok_nxt = 1'b0;
            end else begin
              rd_en      = 1'b1;
              use_rd_nxt = 1'b1;
              head_nxt   = step_out;
              count_nxt  = count_r - ONE_C;
            end
          end
          srq_pkg::OP_RDALL: begin
            if (count_r == '0 || limit_r < count_r) begin
              ok_nxt = 1'b0;
            end else begin
              // walk from head without moving it
              rd_en     = 1'b1;
              idx_nxt   = step_out;
              rem_nxt   = count_r;
              state_nxt = S_RA_EMIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RA_EMIT: begin
        load_ok   = 1'b1;
        load_rec  = rd_data;
        load_last = (rem_r == ONE_C);
        rd_addr   = idx_r;
        if (slot_free) begin
          load_out = 1'b1;
          if (rem_r == ONE_C) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next record while this one goes out
            rd_en   = 1'b1;
            idx_nxt = step_out;
            rem_nxt = rem_r - ONE_C;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // capacity write empties the queue
    if (cfg_we) begin
      cap_nxt   = cap_wr;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= DEPTH_C;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    ok_r     <= ok_nxt;
    use_rd_r <= use_rd_nxt;
    if (in_xfer) begin
      op_r            <= in_op;
      rec_r.resp      <= in_resp_in;
      rec_r.ecg       <= in_ecg_in;
      rec_r.left_off  <= in_left_off_in;
      rec_r.right_off <= in_right_off_in;
      rec_r.ecg_on    <= in_ecg_on_in;
      limit_r         <= in_read_limit;
    end
    if (load_out) begin
      out_ok_r    <= load_ok;
      out_rec_r   <= load_rec;
      out_last_r  <= load_last;
      out_count_r <= count_r;
      out_full_r  <= (count_r == cap_r);
      out_empty_r <= (count_r == '0);
    end
  end

  srq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (rec_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_resp_out      = out_rec_r.resp;
  assign out_ecg_out       = out_rec_r.ecg;
  assign out_left_off_out  = out_rec_r.left_off;
  assign out_right_off_out = out_rec_r.right_off;
  assign out_ecg_on_out    = out_rec_r.ecg_on;
  assign out_last          = out_last_r;
  assign out_count         = out_count_r;
  assign out_full_res      = out_full_r;
  assign out_empty_res     = out_empty_r;

endmodule

`default_nettype wire

/* tb/sample_ring_queue_with_snapshot_tb.sv */
// ---------------------------------------------------------------------------
// sample_ring_queue_with_snapshot_tb: self-checking bench for the sample queue
// drives enqueue, dequeue, read-all and status transfers with random gaps on
// both channels, predicts every result from a local copy of the queue state
// and compares each result field by field, in order
// ---------------------------------------------------------------------------

module sample_ring_queue_with_snapshot_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 64;
  localparam int HOLD_OFF_CYCLES = 250;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int SETTLE_CYCLES   = 8;     // quiet time after the last result

  // one result as the block should report it
  typedef struct {
    logic                      ok;
    srq_pkg::rec_t             rec;
    logic                      last;
    logic [srq_pkg::CNT_W-1:0] count;
    logic                      full;
    logic                      empty;
  } queue_result_t;

  // clock, reset and ports
  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                cfg_we;
  logic [srq_pkg::CNT_W-1:0]           cfg_wdata;
  logic                                in_valid;
  logic                                in_stall;
  logic [1:0]                          in_op;
  logic signed [srq_pkg::SAMPLE_W-1:0] in_resp_in;
  logic signed [srq_pkg::SAMPLE_W-1:0] in_ecg_in;
  logic                                in_left_off_in;
  logic                                in_right_off_in;
  logic                                in_ecg_on_in;
  logic [srq_pkg::CNT_W-1:0]           in_read_limit;
  logic                                out_valid;
  logic                                out_stall;
  logic                                out_ok;
  logic signed [srq_pkg::SAMPLE_W-1:0] out_resp_out;
  logic signed [srq_pkg::SAMPLE_W-1:0] out_ecg_out;
  logic                                out_left_off_out;
  logic                                out_right_off_out;
  logic                                out_ecg_on_out;
  logic                                out_last;
  logic [srq_pkg::CNT_W-1:0]           out_count;
  logic                                out_full_res;
  logic                                out_empty_res;

  // local copy of the queue: records, indices, fill and capacity in use
  srq_pkg::rec_t ring_store [DEPTH];
  int            ring_head;
  int            ring_tail;
  int            ring_fill;
  int            ring_cap;

  // results still owed by the block, oldest first
  queue_result_t awaited_results [$];

  int mismatches;
  int sender_idle_pct;       // chance per cycle that the sender holds back
  int recv_stall_pct;        // chance per cycle that the receiver stalls
  int stall_hold_request;    // asks the receiver for a long hold-off
  int hold_left;
  int quiet_cycles;

  sample_ring_queue_with_snapshot #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_resp_in       (in_resp_in),
    .in_ecg_in        (in_ecg_in),
    .in_left_off_in   (in_left_off_in),
    .in_right_off_in  (in_right_off_in),
    .in_ecg_on_in     (in_ecg_on_in),
    .in_read_limit    (in_read_limit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_resp_out     (out_resp_out),
    .out_ecg_out      (out_ecg_out),
    .out_left_off_out (out_left_off_out),
    .out_right_off_out(out_right_off_out),
    .out_ecg_on_out   (out_ecg_on_out),
    .out_last         (out_last),
    .out_count        (out_count),
    .out_full_res     (out_full_res),
    .out_empty_res    (out_empty_res)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // queue behavior
  // ---------------------------------------------------------------------------

  // index step with wrap at the capacity in use
  function automatic int ring_next(int idx);
    int n;
    n = idx + 1;
    if (n >= ring_cap) n = 0;
    return n;
  endfunction

  // queue one awaited result; count and flags reflect the state after the op
  function automatic void owe_result(logic ok, srq_pkg::rec_t rec, logic last);
    queue_result_t r;
    r.ok    = ok;
    r.rec   = rec;
    r.last  = last;
    r.count = ring_fill[srq_pkg::CNT_W-1:0];
    r.full  = (ring_fill == ring_cap);
    r.empty = (ring_fill == 0);
    awaited_results.push_back(r);
  endfunction

  // apply one accepted operation to the local queue and owe its results
  function automatic void ring_apply(logic [1:0] op, srq_pkg::rec_t rec_in,
                                     logic [srq_pkg::CNT_W-1:0] limit);
    int idx;
    case (op)
      srq_pkg::OP_ENQ: begin
        if (ring_fill >= ring_cap) begin
          owe_result(1'b0, '0, 1'b1);          // full: refused, state kept
        end else begin
          ring_store[ring_tail] = rec_in;
          ring_tail = ring_next(ring_tail);
          ring_fill++;
          owe_result(1'b1, '0, 1'b1);
        end
      end
      srq_pkg::OP_DEQ: begin
        if (ring_fill == 0) begin
          owe_result(1'b0, '0, 1'b1);          // empty: refused
        end else begin
          idx = ring_head;
          ring_head = ring_next(ring_head);
          ring_fill--;
          owe_result(1'b1, ring_store[idx], 1'b1);
        end
      end
      srq_pkg::OP_RDALL: begin
        // empty queue or a caller buffer below the count gives one refusal
        if (ring_fill == 0 || int'(limit) < ring_fill) begin
          owe_result(1'b0, '0, 1'b1);
        end else begin
          idx = ring_head;
          for (int i = 0; i < ring_fill; i++) begin
            owe_result(1'b1, ring_store[idx], (i == ring_fill - 1));
            idx = ring_next(idx);
          end
        end
      end
      default: begin
        owe_result(1'b1, '0, 1'b1);            // status only
      end
    endcase
  endfunction

  // capacity write: clamp to 1..DEPTH and empty the queue
  function automatic void ring_set_capacity(logic [srq_pkg::CNT_W-1:0] v);
    if (v < 1) ring_cap = 1;
    else if (v > DEPTH) ring_cap = DEPTH;
    else ring_cap = int'(v);
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
  endfunction

  function automatic srq_pkg::rec_t make_rec(int resp, int ecg, logic lo, logic ro,
                                             logic on);
    srq_pkg::rec_t r;
    r.resp      = resp[srq_pkg::SAMPLE_W-1:0];
    r.ecg       = ecg[srq_pkg::SAMPLE_W-1:0];
    r.left_off  = lo;
    r.right_off = ro;
    r.ecg_on    = on;
    return r;
  endfunction

  function automatic srq_pkg::rec_t random_rec();
    return make_rec($urandom, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // offer one operation after a random gap; valid stays up until the transfer
  task automatic send_op(logic [1:0] op, srq_pkg::rec_t rec,
                         logic [srq_pkg::CNT_W-1:0] limit);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_op           = op;
    in_resp_in      = rec.resp;
    in_ecg_in       = rec.ecg;
    in_left_off_in  = rec.left_off;
    in_right_off_in = rec.right_off;
    in_ecg_on_in    = rec.ecg_on;
    in_read_limit   = limit;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge: predict now, results come back in order
    ring_apply(op, rec, limit);
  endtask

  // sender pauses until every awaited result has come, then a short settle
  task automatic wait_queue_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // capacity writes only with the block idle
  task automatic write_capacity(logic [srq_pkg::CNT_W-1:0] v);
    wait_queue_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    ring_set_capacity(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a long hold-off counted here when requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_hold_request > 0) begin
      hold_left = stall_hold_request;
      stall_hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every result transfer against the oldest awaited result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, ok %0b count %0d",
                                  out_ok, out_count));
      end else begin
        want = awaited_results.pop_front();
        compare_field("ok", 32'(out_ok), 32'(want.ok));
        compare_field("resp", 32'(out_resp_out), 32'(want.rec.resp));
        compare_field("ecg", 32'(out_ecg_out), 32'(want.rec.ecg));
        compare_field("left_off", 32'(out_left_off_out), 32'(want.rec.left_off));
        compare_field("right_off", 32'(out_right_off_out), 32'(want.rec.right_off));
        compare_field("ecg_on", 32'(out_ecg_on_out), 32'(want.rec.ecg_on));
        compare_field("last", 32'(out_last), 32'(want.last));
        compare_field("count", 32'(out_count), 32'(want.count));
        compare_field("full", 32'(out_full_res), 32'(want.full));
        compare_field("empty", 32'(out_empty_res), 32'(want.empty));
      end
    end
  end

  // watchdog: too long without any transfer on either channel ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // status, dequeue and read-all on an empty queue
  task automatic test_empty_queue_refusals();
    send_op(srq_pkg::OP_STATUS, random_rec(), 7'd0);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd64);   // empty: refused whatever the limit
  endtask

  // extreme sample values and flags, read-all limits around the count
  task automatic test_extreme_records();
    send_op(srq_pkg::OP_ENQ, make_rec(-8388608, 8388607, 1'b1, 1'b0, 1'b1), 7'd0);
    send_op(srq_pkg::OP_ENQ, make_rec(8388607, -8388608, 1'b0, 1'b1, 1'b0), 7'd0);
    send_op(srq_pkg::OP_ENQ, make_rec(0, 0, 1'b0, 1'b0, 1'b0), 7'd0);
    send_op(srq_pkg::OP_ENQ, make_rec(-1, -1, 1'b1, 1'b1, 1'b1), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd127);  // limit far above count
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd4);    // limit equal to count
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd3);    // one short: refused
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd0);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_STATUS, random_rec(), 7'd0);
  endtask

  // a written zero is taken as one entry: full and empty after each step
  task automatic test_capacity_one();
    write_capacity(7'd0);
    send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);      // full: refused
    send_op(srq_pkg::OP_STATUS, random_rec(), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd1);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);      // empty again: refused
  endtask

  // over-range capacity clamps to the depth; any write empties the queue
  task automatic test_config_clears_queue();
    write_capacity(7'd127);
    send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    write_capacity(7'd5);
    send_op(srq_pkg::OP_STATUS, random_rec(), 7'd0);
    send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
  endtask

  // fill all entries, the largest read-all, then move head and tail so the walk wraps
  task automatic test_full_depth();
    write_capacity(7'(DEPTH));
    repeat (DEPTH) send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'(DEPTH - 1));
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'(DEPTH));
    repeat (10) send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    repeat (10) send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd127);
  endtask

  // receiver holds off while the sender keeps offering: input side backs up
  task automatic test_receiver_hold_off();
    write_capacity(7'd8);
    @(posedge clk);
    stall_hold_request = HOLD_OFF_CYCLES;
    repeat (5) send_op(srq_pkg::OP_ENQ, random_rec(), 7'd0);
    send_op(srq_pkg::OP_RDALL, random_rec(), 7'd8);
    send_op(srq_pkg::OP_STATUS, random_rec(), 7'd0);
    repeat (3) send_op(srq_pkg::OP_DEQ, random_rec(), 7'd0);
    wait_queue_idle();
  endtask

  // bursts of random operations with a bias that changes per burst
  task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct);
    int                        sent;
    int                        enq_pct;
    int                        deq_pct;
    int                        roll;
    logic [1:0]                op;
    logic [srq_pkg::CNT_W-1:0] limit;
    sender_idle_pct = snd_pct;
    recv_stall_pct  = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      // now and then a new capacity, mostly small so that full is reached
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_capacity(7'($urandom_range(1, 4)));
          1:       write_capacity(7'($urandom_range(5, 16)));
          2:       write_capacity(7'(DEPTH));
          default: write_capacity(7'($urandom_range(0, 127)));
        endcase
      end else if ($urandom_range(0, 2) == 0) begin
        wait_queue_idle();
      end
      case ($urandom_range(0, 2))
        0: begin
          enq_pct = 65;
          deq_pct = 15;
        end
        1: begin
          enq_pct = 15;
          deq_pct = 65;
        end
        default: begin
          enq_pct = 40;
          deq_pct = 35;
        end
      endcase
      for (int k = 0; k < 20 && sent < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) op = srq_pkg::OP_ENQ;
        else if (roll < enq_pct + deq_pct) op = srq_pkg::OP_DEQ;
        else if (roll < 92) op = srq_pkg::OP_RDALL;
        else op = srq_pkg::OP_STATUS;
        // read limit: mostly enough room, sometimes one short, sometimes anything
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: limit = 7'(ring_fill + $urandom_range(0, 2));
          6, 7:             limit = (ring_fill > 0) ? 7'(ring_fill - 1) : 7'd0;
          default:          limit = 7'($urandom_range(0, 127));
        endcase
        send_op(op, random_rec(), limit);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches         = 0;
    stall_hold_request = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 7;
    recv_stall_pct     = 72;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_op              = srq_pkg::OP_STATUS;
    in_resp_in         = '0;
    in_ecg_in          = '0;
    in_left_off_in     = 1'b0;
    in_right_off_in    = 1'b0;
    in_ecg_on_in       = 1'b0;
    in_read_limit      = '0;
    out_stall          = 1'b0;
    ring_cap           = DEPTH;
    ring_head          = 0;
    ring_tail          = 0;
    ring_fill          = 0;

    // hold the synchronous reset, then release it
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part under the first idling mix
    test_empty_queue_refusals();
    test_extreme_records();
    test_capacity_one();
    test_config_clears_queue();
    test_full_depth();
    test_receiver_hold_off();

    // random part: sender rarely idle, then receiver rarely stalled, then neither
    test_random_traffic(66, 7, 72);
    test_random_traffic(66, 72, 7);
    test_random_traffic(66, 0, 0);

    wait_queue_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
